### sv/page_frame_run_allocator_unit_macros.svh
`ifndef PAGE_FRAME_RUN_ALLOCATOR_UNIT_MACROS_SVH
`define PAGE_FRAME_RUN_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define PFRA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define PFRA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### sv/pfra_pkg.sv
package pfra_pkg;

    localparam int MAX_PAGES   = 4096;
    localparam int MAX_REGIONS = 256;
    localparam int PAGE_AW     = $clog2(MAX_PAGES);
    localparam int CNT_W       = $clog2(MAX_PAGES + 1);
    localparam int REG_W       = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int ADDR_W      = 64;
    localparam int REGION_W    = 8;
    localparam int PCOUNT_W    = 13;
    localparam int MODE_W      = 2;
    localparam int STATUS_W    = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD   = 2'd0,
        MODE_ALLOC  = 2'd1,
        MODE_FREE   = 2'd2,
        MODE_UNUSED = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_OOM          = 3'd1,
        ST_NOT_FOUND    = 3'd2,
        ST_ALREADY_FREE = 3'd3,
        ST_FULL         = 3'd4
    } t_status;

    typedef struct packed {
        logic [PAGE_AW-1:0] raddr;
        logic [PAGE_AW-1:0] waddr;
        logic               we_addr;
        logic               we_region;
        logic               we_free;
        logic [ADDR_W-1:0]  wd_addr;
        logic [REG_W-1:0]   wd_region;
        logic               wd_free;
    } t_mem_req;

    typedef struct packed {
        logic [ADDR_W-1:0] rd_addr;
        logic [REG_W-1:0]  rd_region;
        logic              rd_free;
    } t_mem_rsp;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] result_address;
        t_status           status;
    } t_done;

endpackage

### sv/pfra_if.sv
interface pfra_in_if;
    import pfra_pkg::*;
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [ADDR_W-1:0]   page_address;
    logic [REGION_W-1:0] region;
    logic [PCOUNT_W-1:0] page_count;
    modport source (output valid, mode, page_address, region, page_count, input ready);
    modport sink   (input valid, mode, page_address, region, page_count, output ready);
endinterface

interface pfra_out_if;
    import pfra_pkg::*;
    logic                valid;
    logic                ready;
    logic [ADDR_W-1:0]   result_address;
    logic [STATUS_W-1:0] status;
    modport source (output valid, result_address, status, input ready);
    modport sink   (input valid, result_address, status, output ready);
endinterface

### sv/pfra_ram.sv
module pfra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### sv/pfra_ctrl.sv
`include "page_frame_run_allocator_unit_macros.svh"

module pfra_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pfra_in_if.sink           i_in,
    input  logic              i_out_free,
    input  pfra_pkg::t_mem_rsp i_rsp,
    output pfra_pkg::t_mem_req o_req,
    output pfra_pkg::t_done    o_done
);
    import pfra_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_ASCAN = 8'b0000_0010,
        S_AGET  = 8'b0000_0100,
        S_ACAP  = 8'b0000_1000,
        S_AMARK = 8'b0001_0000,
        S_FSRCH = 8'b0010_0000,
        S_FREE  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_n, n_n;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic [PCOUNT_W-1:0] r_count, n_count;
    logic [PAGE_AW-1:0]  r_idx, n_idx;
    logic [PAGE_AW-1:0]  r_pidx, n_pidx;
    logic                r_pv, n_pv;
    logic [PAGE_AW-1:0]  r_start, n_start;
    logic [REG_W-1:0]    r_sreg, n_sreg;
    logic [CNT_W-1:0]    r_len, n_len;
    logic [PAGE_AW-1:0]  r_end, n_end;
    logic [ADDR_W-1:0]   r_res, n_res;
    t_status             r_status, n_status;

    logic                accept;
    logic                last;
    logic [CNT_W-1:0]    v_len;
    logic [PAGE_AW-1:0]  v_start;
    logic [REG_W-1:0]    v_sreg;

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign last       = (r_pidx == PAGE_AW'(r_n - CNT_W'(1)));

    always_comb begin
        n_state  = r_state;
        n_n      = r_n;
        n_addr   = r_addr;
        n_count  = r_count;
        n_idx    = r_idx;
        n_pidx   = r_pidx;
        n_pv     = r_pv;
        n_start  = r_start;
        n_sreg   = r_sreg;
        n_len    = r_len;
        n_end    = r_end;
        n_res    = r_res;
        n_status = r_status;
        v_len    = r_len;
        v_start  = r_start;
        v_sreg   = r_sreg;
        o_req            = '0;
        o_req.raddr      = r_idx;
        o_done           = '0;
        o_done.result_address = r_res;
        o_done.status    = r_status;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_addr  = i_in.page_address;
                    n_count = i_in.page_count;
                    n_res   = '0;
                    n_idx   = '0;
                    n_pv    = 1'b0;
                    n_len   = '0;
                    n_state = S_DONE;
                    unique case (t_mode'(i_in.mode))
                        MODE_LOAD: begin
                            if (32'(r_n) == MAX_PAGES) begin
                                n_status = ST_FULL;
                            end else begin
                                o_req.waddr     = r_n[PAGE_AW-1:0];
                                o_req.we_addr   = 1'b1;
                                o_req.we_region = 1'b1;
                                o_req.we_free   = 1'b1;
                                o_req.wd_addr   = i_in.page_address;
                                o_req.wd_region = REG_W'(i_in.region);
                                o_req.wd_free   = 1'b1;
                                n_n             = r_n + CNT_W'(1);
                                n_status        = ST_OK;
                            end
                        end
                        MODE_ALLOC: begin
                            if (i_in.page_count == '0 ||
                                32'(i_in.page_count) > 32'(r_n)) begin
                                n_status = ST_OOM;
                            end else begin
                                n_state = S_ASCAN;
                            end
                        end
                        MODE_FREE: begin
                            if (i_in.page_count == '0 || r_n == '0) begin
                                n_status = ST_NOT_FOUND;
                            end else begin
                                n_state = S_FSRCH;
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end
            S_ASCAN: begin
                n_idx  = r_idx + PAGE_AW'(1);
                n_pidx = r_idx;
                n_pv   = 1'b1;
                if (r_pv) begin
                    if (!i_rsp.rd_free) begin
                        v_len = '0;
                    end else if (r_len == '0 || i_rsp.rd_region != r_sreg) begin
                        v_start = r_pidx;
                        v_sreg  = i_rsp.rd_region;
                        v_len   = CNT_W'(1);
                    end else begin
                        v_len = r_len + CNT_W'(1);
                    end
                    n_len   = v_len;
                    n_start = v_start;
                    n_sreg  = v_sreg;
                    if (32'(v_len) == 32'(r_count)) begin
                        n_end   = r_pidx;
                        n_state = S_AGET;
                    end else if (last) begin
                        n_status = ST_OOM;
                        n_state  = S_DONE;
                    end
                end
            end
            S_AGET: begin
                o_req.raddr = r_start;
                n_state     = S_ACAP;
            end
            S_ACAP: begin
                n_res   = i_rsp.rd_addr;
                n_idx   = r_start;
                n_state = S_AMARK;
            end
            S_AMARK: begin
                o_req.waddr   = r_idx;
                o_req.we_free = 1'b1;
                o_req.wd_free = 1'b0;
                n_idx         = r_idx + PAGE_AW'(1);
                if (r_idx == r_end) begin
                    n_status = ST_OK;
                    n_state  = S_DONE;
                end
            end
            S_FSRCH: begin
                n_idx  = r_idx + PAGE_AW'(1);
                n_pidx = r_idx;
                n_pv   = 1'b1;
                if (r_pv) begin
                    if (i_rsp.rd_addr == r_addr) begin
                        n_idx   = r_pidx;
                        n_pv    = 1'b0;
                        n_len   = '0;
                        n_state = S_FREE;
                    end else if (last) begin
                        n_status = ST_NOT_FOUND;
                        n_state  = S_DONE;
                    end
                end
            end
            S_FREE: begin
                // read of the next entry overlaps the write of this one
                n_idx  = r_idx + PAGE_AW'(1);
                n_pidx = r_idx;
                n_pv   = 1'b1;
                if (r_pv) begin
                    if (i_rsp.rd_free) begin
                        n_status = ST_ALREADY_FREE;
                        n_state  = S_DONE;
                    end else begin
                        o_req.waddr   = r_pidx;
                        o_req.we_free = 1'b1;
                        o_req.wd_free = 1'b1;
                        n_len         = r_len + CNT_W'(1);
                        if (32'(n_len) == 32'(r_count) || last) begin
                            n_status = ST_OK;
                            n_state  = S_DONE;
                        end
                    end
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_done.valid = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_n     <= '0;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_pv    <= n_pv;
        end
        r_addr   <= n_addr;
        r_count  <= n_count;
        r_idx    <= n_idx;
        r_pidx   <= n_pidx;
        r_start  <= n_start;
        r_sreg   <= n_sreg;
        r_len    <= n_len;
        r_end    <= n_end;
        r_res    <= n_res;
        r_status <= n_status;
    end

    `PFRA_ASSERT_NEXT(a_busy_after_accept, accept, !i_in.ready, "accepted while busy")
    `PFRA_ASSERT_NOW(a_count_range, 1'b1, 32'(r_n) <= MAX_PAGES, "page count overflow")
    `PFRA_ASSERT_NOW(a_done_free, o_done.valid, i_out_free, "result with full output")
    `PFRA_ASSERT_NOW(a_one_write, o_req.we_free && r_state != S_IDLE,
        !o_req.we_addr, "scan wrote address store")
endmodule

### sv/page_frame_run_allocator_unit.sv
// Page frame run allocator, first fit.
// Input channel i_in carries mode, page_address, region and page_count;
// output channel o_out carries result_address and status. Both are
// valid/ready; a transfer happens on a rising edge with both high.
// Mode 0 appends a free page entry (status 4 when the table is full).
// Mode 1 finds the lowest run of page_count free entries in one region,
// marks it used and returns its first address. Mode 2 finds the first
// entry matching page_address and frees up to page_count entries from it.
// A load goes from its transfer through the DONE state into the output
// register. An allocate walks the table one entry per cycle through the
// registered memory read, then reads the run's first address and marks
// the run used; a free searches for the match, then frees entries in turn.
// The walks over the entry memories dominate the work per item.
// One item is in work at a time; the next is taken as soon as the result
// sits in the output register, even if the receiver stalls it there.
// Reset clears the entry count and control; memory contents are left
// as they are and only read data from loaded entries is ever used.
module page_frame_run_allocator_unit (
    input  logic     i_clk,
    input  logic     i_rst_n,
    pfra_in_if.sink  i_in,
    pfra_out_if.source o_out
);
    import pfra_pkg::*;

    t_mem_req          req;
    t_mem_rsp          rsp;
    t_done             done;
    logic              out_free;
    logic              r_ov;
    logic [ADDR_W-1:0] r_res;
    t_status           r_st;

    // output register: free when empty or being drained this cycle
    assign out_free = !r_ov || o_out.ready;

    pfra_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_out_free(out_free),
        .i_rsp     (rsp),
        .o_req     (req),
        .o_done    (done)
    );

    // page address store
    pfra_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_PAGES)) u_addr_ram (
        .i_clk  (i_clk),
        .i_we   (req.we_addr),
        .i_waddr(req.waddr),
        .i_wdata(req.wd_addr),
        .i_raddr(req.raddr),
        .o_rdata(rsp.rd_addr)
    );

    // region store
    pfra_ram #(.WIDTH(REG_W), .DEPTH(MAX_PAGES)) u_region_ram (
        .i_clk  (i_clk),
        .i_we   (req.we_region),
        .i_waddr(req.waddr),
        .i_wdata(req.wd_region),
        .i_raddr(req.raddr),
        .o_rdata(rsp.rd_region)
    );

    // free marks
    pfra_ram #(.WIDTH(1), .DEPTH(MAX_PAGES)) u_free_ram (
        .i_clk  (i_clk),
        .i_we   (req.we_free),
        .i_waddr(req.waddr),
        .i_wdata(req.wd_free),
        .i_raddr(req.raddr),
        .o_rdata(rsp.rd_free)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (done.valid) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
        if (done.valid) begin
            r_res <= done.result_address;
            r_st  <= done.status;
        end
    end

    assign o_out.valid          = r_ov;
    assign o_out.result_address = r_res;
    assign o_out.status         = r_st;
endmodule
